// ===== rtl/wssd_pkg.sv =====
// Shared types, constants and helpers for the WAVE stream sample decoder.
// No dependencies; imported by every module of the block.
package wssd_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_FORMAT = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [3:0] ERR_BAD_TAG     = 4'd0;
	localparam logic [3:0] ERR_TRUNCATED   = 4'd1;
	localparam logic [3:0] ERR_SHORT_FMT   = 4'd2;
	localparam logic [3:0] ERR_MISSING     = 4'd3;
	localparam logic [3:0] ERR_MISALIGNED  = 4'd4;
	localparam logic [3:0] ERR_UNSUPPORTED = 4'd5;
	localparam logic [3:0] ERR_NONFINITE   = 4'd6;
	localparam logic [3:0] ERR_DATA_FIRST  = 4'd7;
	localparam logic [3:0] ERR_SHORT_FILE  = 4'd8;

	typedef enum logic [2:0] {
		MODE_PCM8, MODE_PCM16, MODE_PCM24, MODE_PCM32, MODE_F32, MODE_F64
	} dec_mode_t;

	// One queued result; raw holds the little-endian sample bytes.
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] raw;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [15:0] count;
		logic [3:0]  err;
		logic        fin;
		dec_mode_t   mode;
	} rec_t;

	function automatic rec_t err_rec(input logic [3:0] code);
		rec_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.err  = code;
		r.fin  = 1'b1;
		return r;
	endfunction

	function automatic logic [7:0] riff_byte(input logic [1:0] i);
		case (i)
			2'd0: riff_byte = 8'h52;
			2'd1: riff_byte = 8'h49;
			2'd2: riff_byte = 8'h46;
			default: riff_byte = 8'h46;
		endcase
	endfunction

	function automatic logic [7:0] wave_byte(input logic [1:0] i);
		case (i)
			2'd0: wave_byte = 8'h57;
			2'd1: wave_byte = 8'h41;
			2'd2: wave_byte = 8'h56;
			default: wave_byte = 8'h45;
		endcase
	endfunction

endpackage

// ===== rtl/wssd_front.sv =====
// Front end: RIFF/chunk parser, fmt capture, sample byte assembly, alignment check.
// Depends on wssd_pkg; feeds wssd_queue with up to two records per byte.
module wssd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    byte_in,
	input  logic          end_of_file,
	input  logic          q_room2,
	output logic          push0,
	output logic          push1,
	output wssd_pkg::rec_t rec0,
	output wssd_pkg::rec_t rec1
);
	import wssd_pkg::*;

	typedef enum logic [2:0] {
		PH_RIFF, PH_CHDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_DRAIN, PH_DIV
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [4:0]  pos_q, n_pos;
	logic [31:0] tag_q, n_tag;
	logic [32:0] rem_q, n_rem;
	logic [15:0] fmt_q, n_fmt, chans_q, n_chans, bits_q, n_bits, chan_q, n_chan;
	logic [31:0] rate_q, n_rate;
	logic [63:0] shift_q, n_shift, newshift;
	logic [3:0]  scnt_q, n_scnt;
	logic        fmt_seen_q, n_fmt_seen, data_taken_q, n_data_taken;
	logic        pad_q, n_pad, eof_pend_q, n_eof_pend;
	logic [29:0] align_q;
	logic [32:0] div_rem_q, n_div_rem, div_t;
	logic [31:0] div_num_q, n_div_num;
	logic [5:0]  div_cnt_q, n_div_cnt;

	logic [13:0] bps;
	logic        supported, accept, err_v, go_chdr, finish, do_reset, no_final, nf;
	logic [3:0]  err_c;
	dec_mode_t   mode;
	rec_t        erec;

	assign bps = 14'((17'(bits_q) + 17'd7) >> 3);

	always_comb begin
		supported = 1'b0;
		mode = MODE_PCM8;
		if (fmt_q == 16'd1) begin
			case (bits_q)
				16'd8:  begin supported = 1'b1; mode = MODE_PCM8;  end
				16'd16: begin supported = 1'b1; mode = MODE_PCM16; end
				16'd24: begin supported = 1'b1; mode = MODE_PCM24; end
				16'd32: begin supported = 1'b1; mode = MODE_PCM32; end
				default: supported = 1'b0;
			endcase
		end else if (fmt_q == 16'd3) begin
			case (bits_q)
				16'd32: begin supported = 1'b1; mode = MODE_F32; end
				16'd64: begin supported = 1'b1; mode = MODE_F64; end
				default: supported = 1'b0;
			endcase
		end
	end

	assign in_stall = (phase_q == PH_DIV) || !q_room2;
	assign accept   = in_valid && !in_stall;
	assign newshift = shift_q | (64'(byte_in) << {scnt_q[2:0], 3'b000});
	assign div_t    = {div_rem_q[31:0], div_num_q[31]};

	always_comb begin
		n_phase = phase_q; n_pos = pos_q; n_tag = tag_q; n_rem = rem_q;
		n_fmt = fmt_q; n_chans = chans_q; n_bits = bits_q; n_rate = rate_q;
		n_chan = chan_q; n_shift = shift_q; n_scnt = scnt_q;
		n_fmt_seen = fmt_seen_q; n_data_taken = data_taken_q;
		n_pad = pad_q; n_eof_pend = eof_pend_q;
		n_div_rem = div_rem_q; n_div_num = div_num_q; n_div_cnt = div_cnt_q;
		push0 = 1'b0; push1 = 1'b0; rec0 = '0; rec1 = '0;
		err_v = 1'b0; err_c = ERR_BAD_TAG;
		go_chdr = 1'b0; finish = 1'b0; do_reset = 1'b0; no_final = 1'b0; nf = 1'b0;
		erec = '0;

		if (accept) begin
			case (phase_q)
				PH_RIFF: begin
					if (pos_q < 5'd4 && byte_in != riff_byte(pos_q[1:0])) err_v = 1'b1;
					if (pos_q >= 5'd8 && pos_q < 5'd12 && byte_in != wave_byte(pos_q[1:0]))
						err_v = 1'b1;
					err_c = ERR_BAD_TAG;
					n_pos = pos_q + 5'd1;
					if (pos_q == 5'd11) go_chdr = 1'b1;
				end
				PH_CHDR: begin
					if (pos_q < 5'd4) n_tag = tag_q | (32'(byte_in) << {pos_q[1:0], 3'b000});
					else n_rem = rem_q | (33'(byte_in) << {pos_q[1:0], 3'b000});
					n_pos = pos_q + 5'd1;
					if (pos_q == 5'd7) begin
						n_pos = '0;
						n_pad = n_rem[0];
						if (n_tag == TAG_FMT) begin
							if (n_rem < 33'd16) begin
								err_v = 1'b1; err_c = ERR_SHORT_FMT;
							end else begin
								n_fmt = '0; n_chans = '0; n_rate = '0; n_bits = '0;
								n_fmt_seen = 1'b1;
								n_phase = PH_FMT;
							end
						end else if (n_tag == TAG_DATA && !data_taken_q) begin
							if (!fmt_seen_q) begin
								err_v = 1'b1; err_c = ERR_DATA_FIRST;
							end else if (fmt_q == '0 || chans_q == '0 || rate_q == '0 ||
									bits_q == '0 || n_rem == '0) begin
								err_v = 1'b1; err_c = ERR_MISSING;
							end else begin
								// size % (bytes per sample * channels), one bit a cycle
								n_phase = PH_DIV;
								n_eof_pend = end_of_file;
								n_div_rem = '0;
								n_div_num = n_rem[31:0];
								n_div_cnt = '0;
								no_final = 1'b1;
							end
						end else begin
							n_phase = PH_SKIP;
						end
						if (!err_v && n_rem == '0) finish = 1'b1;
					end
				end
				PH_FMT: begin
					case (pos_q)
						5'd0:  n_fmt[7:0]    = byte_in;
						5'd1:  n_fmt[15:8]   = byte_in;
						5'd2:  n_chans[7:0]  = byte_in;
						5'd3:  n_chans[15:8] = byte_in;
						5'd4:  n_rate[7:0]   = byte_in;
						5'd5:  n_rate[15:8]  = byte_in;
						5'd6:  n_rate[23:16] = byte_in;
						5'd7:  n_rate[31:24] = byte_in;
						5'd14: n_bits[7:0]   = byte_in;
						5'd15: n_bits[15:8]  = byte_in;
						default: n_fmt = fmt_q;
					endcase
					n_pos = (pos_q == 5'd16) ? pos_q : pos_q + 5'd1;
					n_rem = rem_q - 33'd1;
					if (rem_q == 33'd1) finish = 1'b1;
				end
				PH_DATA: begin
					n_shift = newshift;
					n_scnt = scnt_q + 4'd1;
					if (14'(n_scnt) >= bps) begin
						if (mode == MODE_F32) nf = (newshift[30:23] == 8'hFF);
						else if (mode == MODE_F64) nf = (newshift[62:52] == 11'h7FF);
						if (nf) begin
							err_v = 1'b1; err_c = ERR_NONFINITE;
						end else begin
							push0 = 1'b1;
							rec0.kind = KIND_SAMPLE;
							rec0.raw  = newshift;
							rec0.chan = chan_q;
							rec0.mode = mode;
							n_chan = (17'(chan_q) + 17'd1 >= 17'(chans_q)) ? '0 :
								chan_q + 16'd1;
						end
						n_shift = '0;
						n_scnt = '0;
					end
					if (!err_v) begin
						n_rem = rem_q - 33'd1;
						if (rem_q == 33'd1) finish = 1'b1;
					end
				end
				PH_SKIP: begin
					n_rem = rem_q - 33'd1;
					if (rem_q == 33'd1) finish = 1'b1;
				end
				PH_PAD: go_chdr = 1'b1;
				PH_DRAIN: begin
					no_final = 1'b1;
					if (end_of_file) do_reset = 1'b1;
				end
				default: no_final = 1'b1;
			endcase

			if (go_chdr || finish) begin
				n_phase = PH_CHDR; n_pos = '0; n_tag = '0; n_rem = '0;
			end
			if (finish) begin
				if (n_pad) n_phase = PH_PAD;
				n_pad = 1'b0;
			end

			if (!no_final) begin
				if (err_v) begin
					erec = err_rec(err_c);
					if (end_of_file) do_reset = 1'b1;
					else n_phase = PH_DRAIN;
				end else if (end_of_file) begin
					if (n_phase == PH_FMT || n_phase == PH_DATA || n_phase == PH_SKIP)
						erec = err_rec(ERR_TRUNCATED);
					else if (n_phase == PH_RIFF) erec = err_rec(ERR_SHORT_FILE);
					else if (data_taken_q) begin
						erec = err_rec(ERR_BAD_TAG);
						erec.kind = KIND_END;
					end else erec = err_rec(ERR_MISSING);
					do_reset = 1'b1;
				end
				if (err_v || end_of_file) begin
					if (push0) begin push1 = 1'b1; rec1 = erec; end
					else begin push0 = 1'b1; rec0 = erec; end
				end
			end
		end else if (phase_q == PH_DIV) begin
			if (div_cnt_q != 6'd32) begin
				n_div_rem = (div_t >= 33'(align_q)) ? div_t - 33'(align_q) : div_t;
				n_div_num = {div_num_q[30:0], 1'b0};
				n_div_cnt = div_cnt_q + 6'd1;
			end else if (q_room2) begin
				if (div_rem_q != '0) begin
					err_v = 1'b1; err_c = ERR_MISALIGNED;
				end else if (!supported) begin
					err_v = 1'b1; err_c = ERR_UNSUPPORTED;
				end
				if (err_v) begin
					push0 = 1'b1; rec0 = err_rec(err_c);
					if (eof_pend_q) do_reset = 1'b1;
					else n_phase = PH_DRAIN;
				end else begin
					n_data_taken = 1'b1;
					n_shift = '0; n_scnt = '0; n_chan = '0;
					push0 = 1'b1;
					rec0.kind  = KIND_FORMAT;
					rec0.rate  = rate_q;
					rec0.count = chans_q;
					n_phase = PH_DATA;
					if (eof_pend_q) begin
						push1 = 1'b1; rec1 = err_rec(ERR_TRUNCATED);
						do_reset = 1'b1;
					end
				end
			end
		end

		if (do_reset) begin
			n_phase = PH_RIFF; n_pos = '0; n_tag = '0; n_rem = '0;
			n_fmt = '0; n_chans = '0; n_bits = '0; n_rate = '0;
			n_chan = '0; n_shift = '0; n_scnt = '0;
			n_fmt_seen = 1'b0; n_data_taken = 1'b0; n_pad = 1'b0; n_eof_pend = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF; pos_q <= '0; tag_q <= '0; rem_q <= '0;
			fmt_q <= '0; chans_q <= '0; bits_q <= '0; rate_q <= '0;
			chan_q <= '0; shift_q <= '0; scnt_q <= '0;
			fmt_seen_q <= 1'b0; data_taken_q <= 1'b0; pad_q <= 1'b0; eof_pend_q <= 1'b0;
			div_rem_q <= '0; div_num_q <= '0; div_cnt_q <= '0; align_q <= '0;
		end else begin
			phase_q <= n_phase; pos_q <= n_pos; tag_q <= n_tag; rem_q <= n_rem;
			fmt_q <= n_fmt; chans_q <= n_chans; bits_q <= n_bits; rate_q <= n_rate;
			chan_q <= n_chan; shift_q <= n_shift; scnt_q <= n_scnt;
			fmt_seen_q <= n_fmt_seen; data_taken_q <= n_data_taken;
			pad_q <= n_pad; eof_pend_q <= n_eof_pend;
			div_rem_q <= n_div_rem; div_num_q <= n_div_num; div_cnt_q <= n_div_cnt;
			align_q <= 30'(bps) * 30'(chans_q);
		end
	end

endmodule

// ===== rtl/wssd_queue.sv =====
// Small record queue between parser and decoder: two writes, one read per cycle.
// Depends on wssd_pkg for the record type.
module wssd_queue #(
	parameter int Depth = wssd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push0,
	input  logic           push1,
	input  wssd_pkg::rec_t din0,
	input  wssd_pkg::rec_t din1,
	output logic           room2,
	input  logic           pop,
	output wssd_pkg::rec_t head,
	output logic           nonempty
);
	import wssd_pkg::*;

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	rec_t          ent_q [Depth];
	logic [PW-1:0] wr_q, rd_q, wr1;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
		step = (p == PW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr1      = step(wr_q);
	assign head     = ent_q[rd_q];
	assign nonempty = (cnt_q != '0);
	assign room2    = (cnt_q <= CW'(Depth - 2));

	always_ff @(posedge clk) begin
		if (push0) ent_q[wr_q] <= din0;
		if (push1) ent_q[wr1] <= din1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push1) wr_q <= step(wr1);
			else if (push0) wr_q <= wr1;
			if (pop) rd_q <= step(rd_q);
			cnt_q <= cnt_q + CW'(push0) + CW'(push1) - CW'(pop);
		end
	end

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0) else $error("second write without first");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> room2) else $error("queue written without room");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue read while empty");
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(Depth)) else $error("queue count past depth");

endmodule

// ===== rtl/wssd_back.sv =====
// Back end: converts queued records to Q1.31 results and holds the output register.
// Depends on wssd_pkg.
module wssd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_nonempty,
	input  wssd_pkg::rec_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     kind,
	output logic signed [31:0] sample_value,
	output logic [15:0]    channel_index,
	output logic [31:0]    rate_hz,
	output logic [15:0]    channel_count,
	output logic [3:0]     error_code,
	output logic           final_result
);
	import wssd_pkg::*;

	logic [7:0]  e8, sh8;
	logic [10:0] e11, sh11;
	logic [23:0] sig24;
	logic [52:0] sig53;
	logic [31:0] mag, q;
	logic        neg, sat;

	always_comb begin
		e8 = head.raw[30:23];
		sig24 = {1'b1, head.raw[22:0]};
		e11 = head.raw[62:52];
		sig53 = {1'b1, head.raw[51:0]};
		sh8 = 8'd119 - e8;
		sh11 = 11'd1044 - e11;
		mag = '0;
		neg = 1'b0;
		sat = 1'b0;
		q = '0;
		case (head.mode)
			MODE_PCM8:  q = {~head.raw[7], head.raw[6:0], 24'h0};
			MODE_PCM16: q = {head.raw[15:0], 16'h0};
			MODE_PCM24: q = {head.raw[23:0], 8'h0};
			MODE_PCM32: q = head.raw[31:0];
			MODE_F32: begin
				neg = head.raw[31];
				if (e8 >= 8'd127) sat = 1'b1;
				else if (e8 == 8'd0) mag = '0;
				else if (e8 >= 8'd119) mag = 32'(sig24) << (e8 - 8'd119);
				else if (sh8 < 8'd32) mag = 32'(sig24) >> sh8[4:0];
				q = sat ? (neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : (neg ? -mag : mag);
			end
			MODE_F64: begin
				neg = head.raw[63];
				if (e11 >= 11'd1023) sat = 1'b1;
				else if (e11 != 11'd0 && sh11 < 11'd64) mag = 32'(sig53 >> sh11[5:0]);
				q = sat ? (neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : (neg ? -mag : mag);
			end
			default: q = '0;
		endcase
	end

	assign pop = q_nonempty && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= q_nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind          <= head.kind;
			sample_value  <= (head.kind == KIND_SAMPLE) ? q : '0;
			channel_index <= head.chan;
			rate_hz       <= head.rate;
			channel_count <= head.count;
			error_code    <= head.err;
			final_result  <= head.fin;
		end
	end

endmodule

// ===== rtl/wav_stream_sample_decoder_top.sv =====
// WAVE byte stream to Q1.31 sample decoder, top level.
// Throughput: one byte per cycle unless stalled; a cycle emits up to two records
// into a 4-deep queue.
// The first data chunk header stalls the input for a bit-serial size check.
// Reset (arst_n low, asynchronous) returns the parser to the RIFF header and
// empties the queue and output register.
module wav_stream_sample_decoder_top #(
	parameter int QueueDepth = wssd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         byte_in,
	input  logic               end_of_file,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic signed [31:0] sample_value,
	output logic [15:0]        channel_index,
	output logic [31:0]        rate_hz,
	output logic [15:0]        channel_count,
	output logic [3:0]         error_code,
	output logic               final_result
);
	import wssd_pkg::*;

	// front -> queue: up to two records per transfer
	logic push0, push1, room2, pop, q_nonempty;
	rec_t rec0, rec1, head;

	// Parser: tag checks, chunk walk, fmt capture, sample byte assembly.
	// Nonfinite floats are caught here since they end the run.
	wssd_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .byte_in, .end_of_file,
		.q_room2(room2), .push0, .push1, .rec0, .rec1
	);

	// Decouples the parser from output stalls.
	wssd_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .push0, .push1, .din0(rec0), .din1(rec1),
		.room2, .pop, .head, .nonempty(q_nonempty)
	);

	// Sample widening / float clamp and output register.
	wssd_back u_back (
		.clk, .arst_n, .q_nonempty, .head, .pop, .out_valid, .out_stall,
		.kind, .sample_value, .channel_index, .rate_hz, .channel_count,
		.error_code, .final_result
	);

endmodule

// ===== tb/sv/tb_wav_stream_sample_decoder_top.sv =====
// Self-checking bench for wav_stream_sample_decoder_top: WAVE files, clean and broken,
// are streamed byte by byte; an in-bench parser predicts every record. Uses wssd_pkg.
module tb_wav_stream_sample_decoder_top;
	import wssd_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEM_TARGET = 800;

	// file shape options for the generator
	localparam int FL_JUNK       = 1;   // odd-sized unknown chunk ahead of fmt
	localparam int FL_FMT_ODD    = 2;   // fmt of 17 bytes, so a pad byte follows
	localparam int FL_DATA_FIRST = 4;   // data chunk before any fmt
	localparam int FL_TWO_FMT    = 8;   // garbage fmt overwritten by the real one
	localparam int FL_TAIL       = 16;  // second data chunk after the first, skipped
	localparam int FL_EXTREME    = 32;  // sample values from the corner table
	localparam int FL_SHORT_FMT  = 64;  // fmt size below 16
	localparam int FL_BAD_SIZE   = 128; // data size one byte off

	localparam logic [15:0] FMT_PCM   = 16'd1;
	localparam logic [15:0] FMT_FLOAT = 16'd3;

	typedef enum logic [2:0] {
		PH_RIFF, PH_CHDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_DRAIN
	} phase_t;

	typedef struct {
		logic [7:0] b;
		logic       eof;
		bit         hold;   // sender waits for all records before this transfer
	} byte_item_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] val;
		logic [15:0] ch;
		logic [31:0] rate;
		logic [15:0] cnt;
		logic [3:0]  err;
		logic        fin;
	} record_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         byte_in;
	logic               end_of_file;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         kind;
	logic signed [31:0] sample_value;
	logic [15:0]        channel_index;
	logic [31:0]        rate_hz;
	logic [15:0]        channel_count;
	logic [3:0]         error_code;
	logic               final_result;

	byte_item_t pending_bytes[$];
	record_t    expected_records[$];
	int         cyc = 0;
	int         fails = 0;
	bit         in_took = 1'b0;

	wav_stream_sample_decoder_top dut (.*);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// Parser mirror: state of the file walk
	// ---------------------------------------------------------------
	phase_t      ph;
	int unsigned bpos;
	logic [31:0] ctag;
	logic [63:0] crem;
	logic [15:0] ftag, chans, bits;
	logic [31:0] rate;
	logic [63:0] shf;
	int unsigned sbc;
	logic [15:0] chc;
	logic [1:0]  seen;    // bit0 fmt seen, bit1 data decoded
	bit          padp;

	task automatic parser_reset();
		ph = PH_RIFF; bpos = 0; ctag = '0; crem = '0;
		ftag = '0; chans = '0; rate = '0; bits = '0;
		shf = '0; sbc = 0; chc = '0; seen = '0; padp = 1'b0;
	endtask

	task automatic push_rec(input logic [1:0] k, input logic [31:0] v, input logic [15:0] c,
			input logic [31:0] r, input logic [15:0] n, input logic [3:0] e, input logic f);
		record_t x;
		x.kind = k; x.val = v; x.ch = c; x.rate = r; x.cnt = n; x.err = e; x.fin = f;
		expected_records.insert(expected_records.size(), x);
	endtask

	function automatic int unsigned sample_bytes();
		return (int'(bits) + 7) / 8;
	endfunction

	function automatic bit format_ok();
		if (ftag == FMT_PCM)
			return bits == 8 || bits == 16 || bits == 24 || bits == 32;
		if (ftag == FMT_FLOAT)
			return bits == 32 || bits == 64;
		return 1'b0;
	endfunction

	// Raw little-endian sample to Q1.31; returns 0 for inf/NaN.
	function automatic bit to_q31(input logic [63:0] raw, output logic [31:0] q);
		int unsigned e;
		logic [63:0] sig;
		logic [31:0] mag;
		bit          neg;
		mag = '0;
		q = '0;
		if (ftag == FMT_PCM) begin
			case (bits)
				16'd8:   q = {raw[7:0] ^ 8'h80, 24'd0};
				16'd16:  q = {raw[15:0], 16'd0};
				16'd24:  q = {raw[23:0], 8'd0};
				default: q = raw[31:0];
			endcase
			return 1'b1;
		end
		if (bits == 16'd32) begin
			e = raw[30:23];
			sig = {40'd0, 1'b1, raw[22:0]};
			neg = raw[31];
			if (e == 255) return 1'b0;
			if (e >= 127) begin
				q = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
				return 1'b1;
			end
			if (e == 0) mag = '0;
			else if (e >= 119) mag = 32'(sig << (e - 119));
			else if (119 - e < 32) mag = 32'(sig >> (119 - e));
		end else begin
			e = raw[62:52];
			sig = {11'd0, 1'b1, raw[51:0]};
			neg = raw[63];
			if (e == 2047) return 1'b0;
			if (e >= 1023) begin
				q = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
				return 1'b1;
			end
			if (e != 0 && 1044 - e < 64) mag = 32'(sig >> (1044 - e));
		end
		q = neg ? (32'd0 - mag) : mag;
		return 1'b1;
	endfunction

	task automatic to_chunk_header();
		ph = PH_CHDR; bpos = 0; ctag = '0; crem = '0;
	endtask

	task automatic end_payload();
		bit p;
		p = padp;
		to_chunk_header();
		padp = 1'b0;
		if (p) ph = PH_PAD;
	endtask

	// Chunk header complete: returns an error code or -1.
	task automatic chunk_opened(output int err);
		logic [63:0] sz;
		logic [63:0] align;
		sz = crem;
		err = -1;
		bpos = 0;
		padp = sz[0];
		if (ctag == TAG_FMT) begin
			if (sz < 16) begin
				err = ERR_SHORT_FMT;
				return;
			end
			ftag = '0; chans = '0; rate = '0; bits = '0;
			seen[0] = 1'b1;
			ph = PH_FMT;
		end else if (ctag == TAG_DATA && !seen[1]) begin
			if (!seen[0]) begin err = ERR_DATA_FIRST; return; end
			if (ftag == 0 || chans == 0 || rate == 0 || bits == 0 || sz == 0) begin
				err = ERR_MISSING;
				return;
			end
			align = 64'(sample_bytes()) * chans;
			if (sz % align != 0) begin err = ERR_MISALIGNED; return; end
			if (!format_ok()) begin err = ERR_UNSUPPORTED; return; end
			seen[1] = 1'b1;
			shf = '0; sbc = 0; chc = '0;
			push_rec(KIND_FORMAT, '0, '0, rate, chans, '0, 1'b0);
			ph = PH_DATA;
		end else begin
			ph = PH_SKIP;
		end
		if (sz == 0) end_payload();
	endtask

	// One accepted byte: advance the mirror and queue the records it causes.
	task automatic parse_byte(input logic [7:0] b, input logic eof);
		int          err;
		int unsigned pos;
		logic [31:0] q;
		err = -1;
		pos = bpos;
		case (ph)
			PH_RIFF: begin
				if (pos < 4 && b != riff_byte(pos[1:0])) err = ERR_BAD_TAG;
				if (pos >= 8 && pos < 12 && b != wave_byte(pos[1:0])) err = ERR_BAD_TAG;
				bpos = pos + 1;
				if (bpos >= 12) to_chunk_header();
			end
			PH_CHDR: begin
				if (pos < 4) ctag[8*pos +: 8] = b;
				else crem[8*((pos - 4) & 3) +: 8] = b;
				bpos = pos + 1;
				if (bpos >= 8) chunk_opened(err);
			end
			PH_FMT: begin
				if (pos < 2) ftag[8*pos +: 8] = b;
				else if (pos < 4) chans[8*(pos - 2) +: 8] = b;
				else if (pos < 8) rate[8*(pos - 4) +: 8] = b;
				else if (pos == 14 || pos == 15) bits[8*(pos - 14) +: 8] = b;
				bpos = pos + 1;
				crem = crem - 1;
				if (crem == 0) end_payload();
			end
			PH_DATA: begin
				shf[8*(sbc & 7) +: 8] = b;
				sbc++;
				bpos = pos + 1;
				if (sbc >= sample_bytes()) begin
					if (!to_q31(shf, q)) begin
						err = ERR_NONFINITE;
					end else begin
						push_rec(KIND_SAMPLE, q, chc, '0, '0, '0, 1'b0);
						chc = chc + 1;
						if (chc >= chans) chc = '0;
					end
					shf = '0;
					sbc = 0;
				end
				if (err < 0) begin
					crem = crem - 1;
					if (crem == 0) end_payload();
				end
			end
			PH_SKIP: begin
				bpos = pos + 1;
				crem = crem - 1;
				if (crem == 0) end_payload();
			end
			PH_PAD: to_chunk_header();
			default: begin
				// draining after an error: silent until the last byte
				if (eof) parser_reset();
				return;
			end
		endcase
		if (err >= 0) begin
			push_rec(KIND_ERROR, '0, '0, '0, '0, 4'(err), 1'b1);
			if (eof) parser_reset();
			else ph = PH_DRAIN;
			return;
		end
		if (eof) begin
			if (ph == PH_FMT || ph == PH_DATA || ph == PH_SKIP)
				push_rec(KIND_ERROR, '0, '0, '0, '0, ERR_TRUNCATED, 1'b1);
			else if (ph == PH_RIFF)
				push_rec(KIND_ERROR, '0, '0, '0, '0, ERR_SHORT_FILE, 1'b1);
			else if (seen[1])
				push_rec(KIND_END, '0, '0, '0, '0, '0, 1'b1);
			else
				push_rec(KIND_ERROR, '0, '0, '0, '0, ERR_MISSING, 1'b1);
			parser_reset();
		end
	endtask

	// ---------------------------------------------------------------
	// File generator
	// ---------------------------------------------------------------
	task automatic put_le(inout logic [7:0] fb[$], input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++) fb.insert(fb.size(), v[8*i +: 8]);
	endtask

	task automatic put_chunk_hdr(inout logic [7:0] fb[$], input logic [31:0] tg,
			input logic [31:0] sz);
		put_le(fb, tg, 4);
		put_le(fb, sz, 4);
	endtask

	function automatic logic [63:0] pick_sample(input logic [15:0] tg, input logic [15:0] bt,
			input bit corner, input int k);
		logic [63:0] r;
		int          sel;
		r = {$urandom, $urandom};
		if (corner) begin
			sel = k % 5;
			if (tg == FMT_FLOAT && bt == 16'd32) begin
				case (sel)
					0: r = 64'h3F80_0000;       // +1.0 saturates
					1: r = 64'hC200_0000;       // -32 clamps
					2: r = 64'h0000_0001;       // denormal
					3: r = 64'h3F7F_FFFF;       // just below one
					default: r = 64'h7FC0_0000; // NaN
				endcase
			end else if (tg == FMT_FLOAT) begin
				case (sel)
					0: r = 64'h3FF0_0000_0000_0000;
					1: r = 64'hBFF0_0000_0000_0000;
					2: r = 64'h0000_0000_0000_0001;
					3: r = 64'h3FEF_FFFF_FFFF_FFFF;
					default: r = 64'hFFF0_0000_0000_0000;
				endcase
			end else begin
				case (sel)
					0: r = '0;
					1: r = '1;
					2: r = {8{8'h80}};
					3: r = {8{8'h7F}};
					default: r = {8{8'h01}};
				endcase
			end
		end else if (tg == FMT_FLOAT && bt == 16'd32) begin
			sel = $urandom_range(0, 19);
			r[30:23] = sel == 0 ? 8'hFF : sel == 1 ? 8'h00 : 8'($urandom_range(100, 130));
		end else if (tg == FMT_FLOAT && bt == 16'd64) begin
			sel = $urandom_range(0, 19);
			r[62:52] = sel == 0 ? 11'h7FF : sel == 1 ? 11'h000
				: 11'($urandom_range(1000, 1030));
		end
		return r;
	endfunction

	// Builds one file and queues its bytes; cut < 0 keeps it whole,
	// flip >= 0 corrupts that byte.
	task automatic queue_file(input logic [15:0] tg, input logic [15:0] ch,
			input logic [31:0] rt, input logic [15:0] bt, input int frames,
			input int flags, input int cut, input int flip, input bit hold);
		logic [7:0]  fb[$];
		int          bps, dsize, fsize, last;
		byte_item_t  it;
		bps = (int'(bt) + 7) / 8;
		dsize = frames * bps * int'(ch) + ((flags & FL_BAD_SIZE) ? 1 : 0);
		fsize = (flags & FL_SHORT_FMT) ? 14 : (flags & FL_FMT_ODD) ? 17 : 16;
		put_le(fb, 32'h4646_4952, 4);
		put_le(fb, $urandom, 4);
		put_le(fb, 32'h4556_4157, 4);
		if (flags & FL_DATA_FIRST) begin
			put_chunk_hdr(fb, TAG_DATA, 4);
			put_le(fb, $urandom, 4);
		end
		if (flags & FL_JUNK) begin
			put_chunk_hdr(fb, 32'h4B4E_554A, 3);
			put_le(fb, $urandom, 4);    // 3 payload bytes and the pad
		end
		if (flags & FL_TWO_FMT) begin
			put_chunk_hdr(fb, TAG_FMT, 16);
			put_le(fb, {$urandom, $urandom}, 8);
			put_le(fb, {$urandom, $urandom}, 8);
		end
		put_chunk_hdr(fb, TAG_FMT, fsize);
		put_le(fb, tg, 2);
		put_le(fb, ch, 2);
		put_le(fb, rt, 4);
		put_le(fb, $urandom, 6);          // byte rate and block align
		if (fsize >= 16) put_le(fb, bt, 2);
		if (fsize == 17) put_le(fb, $urandom, 2);  // extra byte and pad
		put_chunk_hdr(fb, TAG_DATA, dsize);
		for (int k = 0; k < frames * int'(ch); k++)
			put_le(fb, pick_sample(tg, bt, (flags & FL_EXTREME) != 0, k), bps);
		if (flags & FL_BAD_SIZE) put_le(fb, $urandom, 1);
		if (dsize % 2) put_le(fb, $urandom, 1);
		if (flags & FL_TAIL) begin
			put_chunk_hdr(fb, TAG_DATA, 5);
			put_le(fb, {$urandom, $urandom}, 6);
		end
		last = (cut >= 0 && cut < fb.size()) ? cut : fb.size() - 1;
		for (int i = 0; i <= last; i++) begin
			it.b = fb[i] ^ ((i == flip) ? 8'($urandom_range(1, 255)) : 8'h00);
			it.eof = (i == last);
			it.hold = hold && i == 0;
			pending_bytes.insert(pending_bytes.size(), it);
		end
	endtask

	task automatic queue_noise(input int n);
		byte_item_t it;
		for (int i = 0; i < n; i++) begin
			it.b = 8'($urandom);
			it.eof = (i == n - 1) || ($urandom_range(0, 15) == 0);
			it.hold = 1'b0;
			pending_bytes.insert(pending_bytes.size(), it);
		end
	endtask

	task automatic queue_random_file(input bit hold);
		logic [15:0] tg, ch, bt;
		logic [31:0] rt;
		int          r, flags, cut, flip, frames;
		r = $urandom_range(0, 9);
		tg = r < 5 ? FMT_PCM : r < 9 ? FMT_FLOAT : 16'($urandom_range(0, 4));
		r = $urandom_range(0, 19);
		if (tg == FMT_FLOAT) bt = r < 10 ? 16'd32 : r < 19 ? 16'd64 : 16'($urandom);
		else bt = r < 19 ? 16'(8 * $urandom_range(1, 4)) : 16'($urandom_range(0, 40));
		ch = $urandom_range(0, 30) == 0 ? 16'd0 : 16'($urandom_range(1, 3));
		rt = $urandom_range(0, 30) == 0 ? 32'd0 : $urandom;
		frames = $urandom_range(0, 20) == 0 ? 0 : $urandom_range(1, 4);
		flags = 0;
		for (int f = 0; f < 8; f++)
			if ($urandom_range(0, 99) < (f == 5 ? 15 : f == 2 || f >= 6 ? 4 : 20))
				flags |= 1 << f;
		if (bt > 16'd64) frames = 0;     // keeps odd depths to a short file
		r = $urandom_range(0, 99);
		cut = r < 12 ? $urandom_range(0, 60) : -1;
		flip = r >= 88 ? $urandom_range(0, 50) : -1;
		queue_file(tg, ch, rt, bt, frames, flags, cut, flip, hold);
	endtask

	// ---------------------------------------------------------------
	// Sender and receiver
	// ---------------------------------------------------------------
	function automatic bit take_break();
		if (cyc >= 300 && cyc < 700) return 1'b0;   // stretch with no idling
		return $urandom_range(0, 99) < 22;
	endfunction

	// driver: new transfer at the falling edge once the last one went through
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (pending_bytes.size() > 0 && !take_break() &&
						!(pending_bytes[0].hold && expected_records.size() != 0)) begin
					in_valid = 1'b1;
					byte_in = pending_bytes[0].b;
					end_of_file = pending_bytes[0].eof;
					void'(pending_bytes.pop_front());
				end else begin
					in_valid = 1'b0;
				end
			end
			out_stall = take_break();
		end
	end

	// monitor: input transfers feed the mirror, output transfers are checked
	always @(posedge clk) begin
		record_t x;
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else if (arst_n) begin
			in_took = in_valid && !in_stall;
			if (in_took) parse_byte(byte_in, end_of_file);
			if (out_valid && !out_stall) begin
				if (expected_records.size() == 0) begin
					fails++;
					$display("%0t: record with none expected, kind %0d", $time, kind);
				end else begin
					x = expected_records.pop_front();
					if (kind !== x.kind || sample_value !== x.val || channel_index !== x.ch ||
							rate_hz !== x.rate || channel_count !== x.cnt ||
							error_code !== x.err || final_result !== x.fin) begin
						fails++;
						$display("%0t: expected kind %0d val %h ch %0d rate %0d cnt %0d err %0d fin %0d",
							$time, x.kind, x.val, x.ch, x.rate, x.cnt, x.err, x.fin);
						$display("%0t: actual   kind %0d val %h ch %0d rate %0d cnt %0d err %0d fin %0d",
							$time, kind, sample_value, channel_index, rate_hz, channel_count,
							error_code, final_result);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = '0;
		end_of_file = 1'b0;
		out_stall = 1'b0;
		parser_reset();

		// directed: every encoding, some with corner samples, then each fault
		queue_file(FMT_PCM, 1, 8000, 8, 5, FL_EXTREME | FL_JUNK, -1, -1, 0);
		queue_file(FMT_PCM, 2, 44100, 16, 1, FL_FMT_ODD, -1, -1, 0);
		queue_file(FMT_PCM, 1, 48000, 24, 3, FL_TWO_FMT | FL_TAIL, -1, -1, 0);
		queue_file(FMT_PCM, 1, 96000, 32, 5, FL_EXTREME, -1, -1, 1);
		queue_file(FMT_FLOAT, 1, 1, 32, 5, FL_EXTREME, -1, -1, 0);   // ends on NaN
		queue_file(FMT_FLOAT, 1, 32'hFFFF_FFFF, 64, 5, FL_EXTREME, -1, -1, 0);
		queue_file(FMT_FLOAT, 1, 100, 32, 4, FL_EXTREME, -1, -1, 0);
		queue_file(FMT_PCM, 1, 8000, 8, 1, 0, -1, 1, 0);             // bad RIFF tag
		queue_file(FMT_PCM, 1, 8000, 8, 1, 0, -1, 9, 0);             // bad WAVE tag
		queue_file(FMT_PCM, 1, 8000, 8, 1, 0, 5, -1, 0);             // short file
		queue_file(FMT_PCM, 1, 8000, 8, 1, FL_SHORT_FMT, -1, -1, 0);
		queue_file(FMT_PCM, 1, 8000, 8, 1, FL_DATA_FIRST, -1, -1, 0);
		queue_file(FMT_PCM, 0, 8000, 8, 1, 0, -1, -1, 0);            // zero channels
		queue_file(FMT_PCM, 2, 8000, 16, 2, FL_BAD_SIZE, -1, -1, 0);
		queue_file(16'd2, 1, 8000, 16, 1, 0, -1, -1, 0);             // unsupported
		queue_file(FMT_PCM, 1, 8000, 16, 3, 0, 46, -1, 0);           // truncated in data
		queue_noise(6);

		while (pending_bytes.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 19) == 0) queue_noise($urandom_range(1, 20));
			else queue_random_file($urandom_range(0, 5) == 0);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
		while (expected_records.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
